// ----- hw/rtl/mba_pkg.sv -----
// Shared types and constants for the memory budget accountant.
`timescale 1ns / 1ps
`default_nettype none

package mba_pkg;

   localparam int AMOUNT_WIDTH    = 40;
   localparam int DELTA_WIDTH     = 32;
   localparam int COUNT_OUT_WIDTH = 32;
   localparam int CSR_DATA_WIDTH  = 40;
   localparam int CSR_INDEX_WIDTH = 1;

   localparam logic [CSR_DATA_WIDTH-1:0] LIMIT_RESET = '1;

   typedef enum logic [2:0] {
      FUNC_RESERVE        = 3'd0,
      FUNC_RELEASE        = 3'd1,
      FUNC_RESERVE_SHARED = 3'd2,
      FUNC_RELEASE_SHARED = 3'd3,
      FUNC_SET_SHARED     = 3'd4,
      FUNC_ADJ_ACTIVE     = 3'd5,
      FUNC_ADJ_PENDING    = 3'd6,
      FUNC_ADJ_OUTGOING   = 3'd7
   } func_type;

   typedef enum logic [1:0] {
      STATUS_OK           = 2'd0,
      STATUS_OVER_REQUEST = 2'd1,
      STATUS_OVER_GLOBAL  = 2'd2,
      STATUS_OVER_HELD    = 2'd3
   } status_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_PER_REQUEST_LIMIT = 1'b0,
      CSR_GLOBAL_LIMIT      = 1'b1
   } csr_index_type;

   typedef struct packed {
      func_type                        func;
      logic [AMOUNT_WIDTH-1:0]         amount;
      logic signed [DELTA_WIDTH-1:0]   delta;
   } req_payload_type;

   typedef struct packed {
      status_type                      status;
      logic [AMOUNT_WIDTH-1:0]         reserved_total;
      logic [AMOUNT_WIDTH-1:0]         peak_total;
      logic [AMOUNT_WIDTH-1:0]         shared_total;
      logic [COUNT_OUT_WIDTH-1:0]      active_count;
      logic [COUNT_OUT_WIDTH-1:0]      pending_count;
      logic [COUNT_OUT_WIDTH-1:0]      outgoing_count;
   } rsp_payload_type;

endpackage

`default_nettype wire

// ----- hw/rtl/mba_stream_if.sv -----
// Valid/ready stream interface with a typed payload.
`timescale 1ns / 1ps
`default_nettype none

interface mba_stream_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/mba_csr.sv -----
// Limit registers written through the configuration port.
`timescale 1ns / 1ps
`default_nettype none

module mba_csr #(
   parameter int BYTE_WIDTH = 40
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_wen,
   input  wire logic [mba_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  wire logic [mba_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata,
   output logic      [BYTE_WIDTH-1:0]                per_request_limit,
   output logic      [BYTE_WIDTH-1:0]                global_limit
);

   localparam logic [63:0] RESET_WIDE = 64'(mba_pkg::LIMIT_RESET);

   logic [63:0]           wdata_wide;
   logic [BYTE_WIDTH-1:0] per_request_ff, per_request_in;
   logic [BYTE_WIDTH-1:0] global_ff, global_in;

   assign wdata_wide = 64'(csr_wdata);

   always_comb begin
      per_request_in = per_request_ff;
      global_in      = global_ff;
      if (csr_wen) begin
         unique case (mba_pkg::csr_index_type'(csr_index))
            mba_pkg::CSR_PER_REQUEST_LIMIT: per_request_in = wdata_wide[BYTE_WIDTH-1:0];
            mba_pkg::CSR_GLOBAL_LIMIT:      global_in      = wdata_wide[BYTE_WIDTH-1:0];
            default:                        per_request_in = per_request_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         per_request_ff <= RESET_WIDE[BYTE_WIDTH-1:0];
         global_ff      <= RESET_WIDE[BYTE_WIDTH-1:0];
      end else begin
         per_request_ff <= per_request_in;
         global_ff      <= global_in;
      end
   end

   assign per_request_limit = per_request_ff;
   assign global_limit      = global_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/mba_ledger.sv -----
// Budget and package counter state with the per-operation update logic.
`timescale 1ns / 1ps
`default_nettype none

module mba_ledger #(
   parameter int BYTE_WIDTH  = 40,
   parameter int COUNT_WIDTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     fire,
   input  wire mba_pkg::req_payload_type op,
   input  wire logic [BYTE_WIDTH-1:0]    per_request_limit,
   input  wire logic [BYTE_WIDTH-1:0]    global_limit,
   output mba_pkg::rsp_payload_type      result
);

   localparam int SUM_WIDTH = BYTE_WIDTH + 2;

   // signed delta: add wraps, subtract clamps at zero
   function automatic logic [COUNT_WIDTH-1:0] adjust(input logic [COUNT_WIDTH-1:0] cur,
                                                     input logic [31:0] d);
      logic [32:0] cur_w;
      logic [32:0] sum;
      logic [32:0] mag;
      logic [32:0] diff;
      cur_w = 33'(cur);
      sum   = cur_w + 33'(d);
      mag   = 33'h1_0000_0000 - 33'(d);
      diff  = cur_w - mag;
      if (d == 32'd0) begin
         return cur;
      end else if (!d[31]) begin
         return sum[COUNT_WIDTH-1:0];
      end else if (cur_w > mag) begin
         return diff[COUNT_WIDTH-1:0];
      end else begin
         return '0;
      end
   endfunction

   logic [BYTE_WIDTH-1:0]  reserved_ff, reserved_in;
   logic [BYTE_WIDTH-1:0]  peak_ff, peak_in;
   logic [BYTE_WIDTH-1:0]  shared_ff, shared_in;
   logic [COUNT_WIDTH-1:0] active_ff, active_in;
   logic [COUNT_WIDTH-1:0] pending_ff, pending_in;
   logic [COUNT_WIDTH-1:0] outgoing_ff, outgoing_in;

   logic [63:0]            amount_wide;
   logic [BYTE_WIDTH-1:0]  amt;
   logic [SUM_WIDTH-1:0]   budget_sum;
   logic                   over_global;
   logic [BYTE_WIDTH-1:0]  reserve_sum;
   mba_pkg::status_type    status;

   logic [63:0]            reserved_wide, peak_wide, shared_wide;

   assign amount_wide = 64'(op.amount);
   assign amt         = amount_wide[BYTE_WIDTH-1:0];

   // exact three-way budget test, two guard bits keep it from wrapping
   assign budget_sum  = SUM_WIDTH'(reserved_ff) + SUM_WIDTH'(shared_ff) + SUM_WIDTH'(amt);
   assign over_global = budget_sum > SUM_WIDTH'(global_limit);
   assign reserve_sum = reserved_ff + amt;

   always_comb begin
      status      = mba_pkg::STATUS_OK;
      reserved_in = reserved_ff;
      peak_in     = peak_ff;
      shared_in   = shared_ff;
      active_in   = active_ff;
      pending_in  = pending_ff;
      outgoing_in = outgoing_ff;
      case (op.func)
         mba_pkg::FUNC_RESERVE: begin
            if (amt > per_request_limit) begin
               status = mba_pkg::STATUS_OVER_REQUEST;
            end else if (over_global) begin
               status = mba_pkg::STATUS_OVER_GLOBAL;
            end else begin
               reserved_in = reserve_sum;
               if (reserve_sum > peak_ff) begin
                  peak_in = reserve_sum;
               end
            end
         end
         mba_pkg::FUNC_RELEASE: begin
            if (amt > reserved_ff) begin
               status = mba_pkg::STATUS_OVER_HELD;
            end else begin
               reserved_in = reserved_ff - amt;
            end
         end
         mba_pkg::FUNC_RESERVE_SHARED: begin
            if (over_global) begin
               status = mba_pkg::STATUS_OVER_GLOBAL;
            end else begin
               shared_in = shared_ff + amt;
            end
         end
         mba_pkg::FUNC_RELEASE_SHARED: begin
            if (amt > shared_ff) begin
               status = mba_pkg::STATUS_OVER_HELD;
            end else begin
               shared_in = shared_ff - amt;
            end
         end
         mba_pkg::FUNC_SET_SHARED:  shared_in   = amt;
         mba_pkg::FUNC_ADJ_ACTIVE:  active_in   = adjust(active_ff, op.delta);
         mba_pkg::FUNC_ADJ_PENDING: pending_in  = adjust(pending_ff, op.delta);
         default:                   outgoing_in = adjust(outgoing_ff, op.delta);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reserved_ff <= '0;
         peak_ff     <= '0;
         shared_ff   <= '0;
         active_ff   <= '0;
         pending_ff  <= '0;
         outgoing_ff <= '0;
      end else if (fire) begin
         reserved_ff <= reserved_in;
         peak_ff     <= peak_in;
         shared_ff   <= shared_in;
         active_ff   <= active_in;
         pending_ff  <= pending_in;
         outgoing_ff <= outgoing_in;
      end
   end

   assign reserved_wide = 64'(reserved_in);
   assign peak_wide     = 64'(peak_in);
   assign shared_wide   = 64'(shared_in);

   always_comb begin
      result.status         = status;
      result.reserved_total = reserved_wide[mba_pkg::AMOUNT_WIDTH-1:0];
      result.peak_total     = peak_wide[mba_pkg::AMOUNT_WIDTH-1:0];
      result.shared_total   = shared_wide[mba_pkg::AMOUNT_WIDTH-1:0];
      result.active_count   = mba_pkg::COUNT_OUT_WIDTH'(active_in);
      result.pending_count  = mba_pkg::COUNT_OUT_WIDTH'(pending_in);
      result.outgoing_count = mba_pkg::COUNT_OUT_WIDTH'(outgoing_in);
   end

   a_peak_covers_reserved: assert property (@(posedge clock) disable iff (reset)
      peak_ff >= reserved_ff)
      else $error("peak fell below reserved total");

   a_refused_keeps_bytes: assert property (@(posedge clock) disable iff (reset)
      fire && (status != mba_pkg::STATUS_OK)
      |=> $stable(reserved_ff) && $stable(shared_ff) && $stable(peak_ff))
      else $error("refused operation changed byte totals");

   a_counter_always_ok: assert property (@(posedge clock) disable iff (reset)
      fire && ((op.func == mba_pkg::FUNC_ADJ_ACTIVE) || (op.func == mba_pkg::FUNC_ADJ_PENDING)
               || (op.func == mba_pkg::FUNC_ADJ_OUTGOING))
      |-> (status == mba_pkg::STATUS_OK) ##1 ($stable(reserved_ff) && $stable(shared_ff)))
      else $error("counter adjust touched byte budget");

endmodule

`default_nettype wire

// ----- hw/rtl/memory_budget_accountant_top.sv -----
// Top level of the memory budget accountant: staging registers, limits and ledger.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake          Payload
// req_if    in   valid/ready        func, amount, delta
// rsp_if    out  valid/ready        status, reserved/peak/shared totals, three counts
// csr_*     in   csr_wen only       csr_index selects limit, csr_wdata holds value
//
// One operation per cycle sustained while rsp_if accepts results. A transfer on
// req_if lands in the input register; once the result register is free or
// draining, the ledger evaluates it against the live state and writes the result
// register, which drives rsp_if.valid.
// The ledger's budget add/compare sets the cycle time.
// Reset (synchronous) clears both staging valids, the ledger state and sets
// both limits to all ones. A stall on rsp_if holds the result register; the
// input register still takes one more item before req_if.ready drops.

module memory_budget_accountant_top #(
   parameter int BYTE_WIDTH  = 40,
   parameter int COUNT_WIDTH = 32
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   mba_stream_if.sink                                req_if,
   mba_stream_if.source                              rsp_if,
   input  wire logic                                 csr_wen,
   input  wire logic [mba_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  wire logic [mba_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata
);

   logic [BYTE_WIDTH-1:0]     per_request_limit;
   logic [BYTE_WIDTH-1:0]     global_limit;

   logic                      in_valid_ff, in_valid_in;
   mba_pkg::req_payload_type  in_data_ff;
   logic                      out_valid_ff, out_valid_in;
   mba_pkg::rsp_payload_type  out_data_ff;
   mba_pkg::rsp_payload_type  ledger_result;

   logic                      req_take;
   logic                      advance;

   mba_csr #(
      .BYTE_WIDTH (BYTE_WIDTH)
   ) u_csr (
      .clock             (clock),
      .reset             (reset),
      .csr_wen           (csr_wen),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .per_request_limit (per_request_limit),
      .global_limit      (global_limit)
   );

   // staged item moves on when the result slot is free or draining
   assign advance  = in_valid_ff && (!out_valid_ff || rsp_if.ready);
   assign req_take = req_if.valid && req_if.ready;

   assign req_if.ready = !in_valid_ff || advance;

   mba_ledger #(
      .BYTE_WIDTH  (BYTE_WIDTH),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_ledger (
      .clock             (clock),
      .reset             (reset),
      .fire              (advance),
      .op                (in_data_ff),
      .per_request_limit (per_request_limit),
      .global_limit      (global_limit),
      .result            (ledger_result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_if.payload;
      end
      if (advance) begin
         out_data_ff <= ledger_result;
      end
   end

   assign rsp_if.valid   = out_valid_ff;
   assign rsp_if.payload = out_data_ff;

   a_advance_fills_result: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("evaluated item produced no result");

   a_blocked_item_held: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_data_ff))
      else $error("staged item lost while result slot busy");

   a_result_held: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && !rsp_if.ready |=> rsp_if.valid && $stable(rsp_if.payload))
      else $error("waiting result changed before its transfer");

endmodule

`default_nettype wire

// ----- sim/memory_budget_accountant_top_tb.sv -----
// Self-checking testbench for the memory budget accountant, checked against a ledger model.
`timescale 1ns / 1ps

module memory_budget_accountant_top_tb;
   import mba_pkg::*;

   localparam logic [AMOUNT_WIDTH-1:0] BYTES_MAX    = '1;
   localparam int                      STALL_CYCLES = 80;
   localparam int                      SETTLE       = 4;    // staging depth plus margin

   logic                       clock;
   logic                       reset;
   logic                       csr_wen;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata;

   mba_stream_if #(.payload_type(req_payload_type)) req_if ();
   mba_stream_if #(.payload_type(rsp_payload_type)) rsp_if ();

   memory_budget_accountant_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .rsp_if    (rsp_if),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Ledger model: limits, byte holdings and package counters.
   logic [AMOUNT_WIDTH-1:0]    limit_request;
   logic [AMOUNT_WIDTH-1:0]    limit_global;
   logic [AMOUNT_WIDTH-1:0]    held_private;
   logic [AMOUNT_WIDTH-1:0]    peak_private;
   logic [AMOUNT_WIDTH-1:0]    held_shared;
   logic [COUNT_OUT_WIDTH-1:0] active_cnt;
   logic [COUNT_OUT_WIDTH-1:0] pending_cnt;
   logic [COUNT_OUT_WIDTH-1:0] outgoing_cnt;

   req_payload_type queued_ops[$];       // ops waiting for the driver
   rsp_payload_type pending_results[$];  // predicted ledger snapshots, oldest first

   bit req_taken;                        // request transfer at the last rising edge
   bit sender_idles   = 1'b1;
   bit receiver_idles = 1'b1;
   bit stall_request;
   int send_gap;
   int recv_gap;
   int hold_left;
   int mismatches;
   int transfers_in;
   int results_seen;
   int limit_settings;
   int status_seen[4];

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------------

   // Exact budget test in two extra bits, so the sum cannot wrap.
   function automatic bit over_budget(input logic [AMOUNT_WIDTH-1:0] amt);
      logic [AMOUNT_WIDTH+1:0] total;
      total = {2'b00, held_private} + {2'b00, held_shared} + {2'b00, amt};
      return total > {2'b00, limit_global};
   endfunction

   // Positive delta wraps, negative delta floors at zero.
   function automatic logic [COUNT_OUT_WIDTH-1:0] nudge_count(
         input logic [COUNT_OUT_WIDTH-1:0] cur, input logic signed [DELTA_WIDTH-1:0] d);
      logic [COUNT_OUT_WIDTH:0] mag;
      if (d == 0) return cur;
      if (d > 0) return cur + d;
      mag = 33'h1_0000_0000 - {1'b0, d};
      return ({1'b0, cur} > mag) ? cur - mag[COUNT_OUT_WIDTH-1:0] : '0;
   endfunction

   function automatic rsp_payload_type apply_op(input req_payload_type op);
      rsp_payload_type snap;
      status_type      st;
      st = STATUS_OK;
      case (op.func)
         FUNC_RESERVE: begin
            if (op.amount > limit_request) st = STATUS_OVER_REQUEST;
            else if (over_budget(op.amount)) st = STATUS_OVER_GLOBAL;
            else begin
               held_private = held_private + op.amount;
               if (held_private > peak_private) peak_private = held_private;
            end
         end
         FUNC_RELEASE: begin
            if (op.amount > held_private) st = STATUS_OVER_HELD;
            else held_private = held_private - op.amount;
         end
         FUNC_RESERVE_SHARED: begin
            if (over_budget(op.amount)) st = STATUS_OVER_GLOBAL;
            else held_shared = held_shared + op.amount;
         end
         FUNC_RELEASE_SHARED: begin
            if (op.amount > held_shared) st = STATUS_OVER_HELD;
            else held_shared = held_shared - op.amount;
         end
         FUNC_SET_SHARED:   held_shared  = op.amount;
         FUNC_ADJ_ACTIVE:   active_cnt   = nudge_count(active_cnt, op.delta);
         FUNC_ADJ_PENDING:  pending_cnt  = nudge_count(pending_cnt, op.delta);
         default:           outgoing_cnt = nudge_count(outgoing_cnt, op.delta);
      endcase
      snap.status         = st;
      snap.reserved_total = held_private;
      snap.peak_total     = peak_private;
      snap.shared_total   = held_shared;
      snap.active_count   = active_cnt;
      snap.pending_count  = pending_cnt;
      snap.outgoing_count = outgoing_cnt;
      return snap;
   endfunction

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (got !== want) begin
         mismatches++;
         $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      end
   endtask

   task automatic check_result(input rsp_payload_type want, input rsp_payload_type got);
      check_field("status", 64'(want.status), 64'(got.status));
      check_field("reserved_total", 64'(want.reserved_total), 64'(got.reserved_total));
      check_field("peak_total", 64'(want.peak_total), 64'(got.peak_total));
      check_field("shared_total", 64'(want.shared_total), 64'(got.shared_total));
      check_field("active_count", 64'(want.active_count), 64'(got.active_count));
      check_field("pending_count", 64'(want.pending_count), 64'(got.pending_count));
      check_field("outgoing_count", 64'(want.outgoing_count), 64'(got.outgoing_count));
   endtask

   // ---------------------------------------------------------------------
   // Monitor: samples both channels and the limit port at the rising edge
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      rsp_payload_type want;
      req_taken = 1'b0;
      if (reset) begin
         limit_request = BYTES_MAX;
         limit_global  = BYTES_MAX;
         held_private  = '0;
         peak_private  = '0;
         held_shared   = '0;
         active_cnt    = '0;
         pending_cnt   = '0;
         outgoing_cnt  = '0;
      end else begin
         if (csr_wen) begin
            if (csr_index == CSR_PER_REQUEST_LIMIT) limit_request = csr_wdata;
            else limit_global = csr_wdata;
         end
         // A request transfer is predicted before a result in the same cycle
         // is popped; the staging registers keep the popped entry the older one.
         if (req_if.valid && req_if.ready) begin
            req_taken = 1'b1;
            transfers_in++;
            pending_results.push_back(apply_op(req_if.payload));
         end
         if (rsp_if.valid && rsp_if.ready) begin
            results_seen++;
            status_seen[rsp_if.payload.status]++;
            if (pending_results.size() == 0) begin
               mismatches++;
               $display("%0t: result with nothing expected, actual %h", $time,
                        rsp_if.payload);
            end else begin
               want = pending_results.pop_front();
               check_result(want, rsp_if.payload);
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Driver: one op per transfer, valid held until taken, random gaps
   // ---------------------------------------------------------------------
   always @(negedge clock) begin : driver
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_taken) begin
         if (send_gap > 0) begin
            send_gap--;
            req_if.valid <= 1'b0;
         end else if (queued_ops.size() > 0) begin
            req_if.valid   <= 1'b1;
            req_if.payload <= queued_ops.pop_front();
            // gap starts once this op has been taken
            if (sender_idles && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 18);
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // Result side: random stall bursts, plus one long hold on request so the
   // staging registers fill and the block drops req ready.
   always @(negedge clock) begin : receiver
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (stall_request) begin
         stall_request = 1'b0;
         hold_left     = STALL_CYCLES - 1;
         rsp_if.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_if.ready <= 1'b0;
      end else if (recv_gap > 0) begin
         recv_gap--;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
         if (receiver_idles && $urandom_range(0, 5) == 0) recv_gap = $urandom_range(1, 18);
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   task automatic queue_op(input func_type f, input logic [AMOUNT_WIDTH-1:0] amt,
                           input logic signed [DELTA_WIDTH-1:0] d);
      req_payload_type op;
      op.func   = f;
      op.amount = amt;
      op.delta  = d;
      queued_ops.push_back(op);
   endtask

   function automatic logic [AMOUNT_WIDTH-1:0] rand_bytes(input logic [63:0] hi);
      logic [63:0] raw;
      raw = {$urandom(), $urandom()};
      return AMOUNT_WIDTH'(raw % (hi + 64'd1));
   endfunction

   // Amounts mostly scaled to the limits in force, so refusals and
   // acceptances both come often; some full-width values and extremes.
   task automatic queue_random(input int n, input logic [AMOUNT_WIDTH-1:0] per,
                               input logic [AMOUNT_WIDTH-1:0] glob);
      req_payload_type op;
      repeat (n) begin
         op.func = func_type'($urandom_range(0, 7));
         case ($urandom_range(0, 15))
            0:             op.amount = '0;
            1:             op.amount = BYTES_MAX;
            2, 3:          op.amount = rand_bytes(64'(BYTES_MAX));
            4, 5, 6, 7, 8: op.amount = rand_bytes(64'(per) + 64'(per >> 2));
            default:       op.amount = rand_bytes(64'(glob >> 3));
         endcase
         case ($urandom_range(0, 7))
            0:       op.delta = '0;
            1:       op.delta = 32'h8000_0000;
            2:       op.delta = 32'h7FFF_FFFF;
            3, 4:    op.delta = $urandom();
            default: op.delta = $urandom_range(0, 400) - 200;
         endcase
         queued_ops.push_back(op);
      end
   endtask

   // Sender pause: nothing in flight, nothing outstanding.
   task automatic drain_all();
      @(negedge clock);
      while (queued_ops.size() != 0 || req_if.valid || pending_results.size() != 0)
         @(negedge clock);
   endtask

   task automatic set_limits(input logic [AMOUNT_WIDTH-1:0] per,
                             input logic [AMOUNT_WIDTH-1:0] glob);
      drain_all();
      repeat (SETTLE) @(negedge clock);
      csr_wen   <= 1'b1;
      csr_index <= CSR_PER_REQUEST_LIMIT;
      csr_wdata <= per;
      @(negedge clock);
      csr_index <= CSR_GLOBAL_LIMIT;
      csr_wdata <= glob;
      @(negedge clock);
      csr_wen <= 1'b0;
      limit_settings++;
   endtask

   initial begin : stimulus
      logic [AMOUNT_WIDTH-1:0] per;
      logic [AMOUNT_WIDTH-1:0] glob;
      reset          = 1'b1;
      csr_wen        = 1'b0;
      csr_index      = CSR_PER_REQUEST_LIMIT;
      csr_wdata      = '0;
      req_if.valid   = 1'b0;
      req_if.payload = '0;
      rsp_if.ready   = 1'b0;
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      // Limits at reset value: full-range reserves and releases.
      queue_op(FUNC_RESERVE, '0, 32'h7FFF_FFFF);         // delta ignored
      queue_op(FUNC_RESERVE, BYTES_MAX, -1);             // fills the budget exactly
      queue_op(FUNC_RESERVE, 40'd1, 0);                  // over global
      queue_op(FUNC_RESERVE_SHARED, 40'd1, 0);           // over global
      queue_op(FUNC_RELEASE, BYTES_MAX, 0);
      queue_op(FUNC_RELEASE, 40'd1, 0);                  // more than held
      queue_op(FUNC_RESERVE_SHARED, BYTES_MAX, 0);
      queue_op(FUNC_RELEASE_SHARED, 40'd1, 0);
      queue_op(FUNC_RELEASE_SHARED, BYTES_MAX, 0);       // more than held
      queue_op(FUNC_SET_SHARED, '0, 0);
      queue_op(FUNC_RELEASE_SHARED, '0, 0);
      queue_op(FUNC_ADJ_ACTIVE, BYTES_MAX, 32'h7FFF_FFFF); // amount ignored
      queue_op(FUNC_ADJ_ACTIVE, '0, 32'h7FFF_FFFF);
      queue_op(FUNC_ADJ_ACTIVE, '0, 2);                  // wraps to zero
      queue_op(FUNC_ADJ_ACTIVE, '0, -1);                 // floors at zero
      queue_op(FUNC_ADJ_PENDING, '0, 32'h8000_0000);
      queue_op(FUNC_ADJ_PENDING, '0, 5);
      queue_op(FUNC_ADJ_PENDING, '0, -3);
      queue_op(FUNC_ADJ_PENDING, '0, 0);                 // zero delta
      queue_op(FUNC_ADJ_OUTGOING, '0, -1);
      queue_op(FUNC_ADJ_OUTGOING, '0, 1);
      queue_op(FUNC_ADJ_OUTGOING, '0, 32'h8000_0000);

      // Tight limits: both tests failing, shared set above the budget,
      // reserve landing exactly on the global limit.
      set_limits(40'd1000, 40'd5000);
      queue_op(FUNC_RESERVE, 40'd6000, 0);               // per-request wins
      queue_op(FUNC_RESERVE, 40'd1001, 0);
      queue_op(FUNC_RESERVE, 40'd1000, 0);
      queue_op(FUNC_SET_SHARED, 40'd8000, 0);
      queue_op(FUNC_RESERVE, 40'd1, 0);
      queue_op(FUNC_RESERVE_SHARED, '0, 0);
      queue_op(FUNC_SET_SHARED, 40'd3000, 0);
      queue_op(FUNC_RESERVE, 40'd1000, 0);               // exactly at the limit
      queue_op(FUNC_RESERVE_SHARED, 40'd1, 0);
      queue_random(200, 40'd1000, 40'd5000);

      // Random limits, sender never idles, receiver holds off once.
      per  = rand_bytes(64'(BYTES_MAX));
      glob = rand_bytes(64'(BYTES_MAX));
      set_limits(per, glob);
      sender_idles = 1'b0;
      @(posedge clock);
      stall_request = 1'b1;
      queue_random(200, per, glob);
      drain_all();
      sender_idles = 1'b1;

      // Zero limits: a reserve, private or shared, passes only with zero bytes on an empty ledger.
      set_limits('0, '0);
      queue_op(FUNC_SET_SHARED, '0, 0);
      queue_op(FUNC_RESERVE_SHARED, '0, 0);
      queue_random(60, '0, '0);

      set_limits(40'h40, 40'h800);
      queue_random(200, 40'h40, 40'h800);

      // Last stretch at full limits with no idling on either side.
      set_limits(BYTES_MAX, BYTES_MAX);
      sender_idles   = 1'b0;
      receiver_idles = 1'b0;
      queue_random(250, BYTES_MAX, BYTES_MAX);

      drain_all();
      repeat (2 * SETTLE) @(posedge clock);
      $display("Covered %0d transfers under %0d limit settings, %0d results checked.",
               transfers_in, limit_settings, results_seen);
      $display("Status ok %0d, over request %0d, over global %0d, over held %0d.",
               status_seen[STATUS_OK], status_seen[STATUS_OVER_REQUEST],
               status_seen[STATUS_OVER_GLOBAL], status_seen[STATUS_OVER_HELD]);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // Watchdog, far beyond the slowest legal run.
   initial begin : watchdog
      #2_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule

// ----- filelist.f -----
hw/rtl/mba_pkg.sv
hw/rtl/mba_stream_if.sv
hw/rtl/mba_csr.sv
hw/rtl/mba_ledger.sv
hw/rtl/memory_budget_accountant_top.sv
sim/memory_budget_accountant_top_tb.sv
